### hdl/dmpb_pkg.sv
// constants and types for the suffix automaton builder
// no dependencies
`timescale 1ns / 1ps

package dmpb_pkg;

   localparam int SYM_W    = 8;
   localparam int NODE_W   = 10;
   localparam int CNT_W    = NODE_W + 1;
   localparam int EADDR_W  = NODE_W + SYM_W;
   localparam int ALPHABET = 1 << SYM_W;
   localparam int NODE_CAP = 1 << NODE_W;
   localparam int PAT_MAX  = NODE_CAP - 1;

   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
   localparam logic [NODE_W-1:0] NO_NODE   = NODE_W'(0);

   typedef struct packed {
      logic [NODE_W-1:0] target;
      logic              primary;
   } edge_type;

endpackage

### hdl/dawg_multi_pattern_builder_unit.sv
// suffix automaton builder: sequencer over edge, link and terminal memories
// depends on dmpb_pkg
//
//  channel | ports                                                   | direction
//  request | req_valid req_ready req_symbol req_first/last_of_pattern | in
//  response| rsp_valid rsp_ready rsp_active_node rsp_nodes_used ...  | out
//
// after reset a clearing pass sweeps every edge, link and terminal entry; no request taken
// a primary hit goes straight to the response; a new node walks the suffix-link chain
// a split copies the edges of the split node and scans the edges of each redirected chain node
// an end of pattern marks each node on the suffix chain below the root as terminal
// one request at a time; a waiting response does not block the next request

`timescale 1ns / 1ps

module dawg_multi_pattern_builder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dmpb_pkg::SYM_W-1:0]    req_symbol,
   input  logic                          req_first_of_pattern,
   input  logic                          req_last_of_pattern,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dmpb_pkg::NODE_W-1:0]   rsp_active_node,
   output logic [dmpb_pkg::CNT_W-1:0]    rsp_nodes_used,
   output logic                          rsp_pattern_done,
   output logic [dmpb_pkg::NODE_W-1:0]   rsp_pattern_index,
   output logic                          rsp_status
);

   localparam int NW = dmpb_pkg::NODE_W;
   localparam int CW = dmpb_pkg::CNT_W;
   localparam int SW = dmpb_pkg::SYM_W;
   localparam int EW = dmpb_pkg::EADDR_W;

   localparam logic [4:0] ST_CLR    = 5'd0;
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_U_RD   = 5'd2;
   localparam logic [4:0] ST_U_WT   = 5'd3;
   localparam logic [4:0] ST_W_CHK  = 5'd4;
   localparam logic [4:0] ST_W_LNK  = 5'd5;
   localparam logic [4:0] ST_W_EDG  = 5'd6;
   localparam logic [4:0] ST_S_TRD  = 5'd7;
   localparam logic [4:0] ST_S_TWT  = 5'd8;
   localparam logic [4:0] ST_S_CRD  = 5'd9;
   localparam logic [4:0] ST_S_CWT  = 5'd10;
   localparam logic [4:0] ST_S_L1   = 5'd11;
   localparam logic [4:0] ST_S_L2   = 5'd12;
   localparam logic [4:0] ST_S_L3   = 5'd13;
   localparam logic [4:0] ST_S_WCHK = 5'd14;
   localparam logic [4:0] ST_S_WLNK = 5'd15;
   localparam logic [4:0] ST_S_ERD  = 5'd16;
   localparam logic [4:0] ST_S_EWT  = 5'd17;
   localparam logic [4:0] ST_FIN    = 5'd18;
   localparam logic [4:0] ST_T_SET  = 5'd19;
   localparam logic [4:0] ST_T_WT   = 5'd20;
   localparam logic [4:0] ST_RESP   = 5'd21;

   // memories
   dmpb_pkg::edge_type edge_mem [dmpb_pkg::NODE_CAP*dmpb_pkg::ALPHABET];
   logic [NW-1:0]      link_mem [dmpb_pkg::NODE_CAP];
   logic               term_mem [dmpb_pkg::NODE_CAP];

   logic               e_re, e_we, l_re, l_we, t_re, t_we;
   logic [EW-1:0]      e_raddr, e_waddr;
   dmpb_pkg::edge_type e_wdata, e_rd_ff;
   logic [NW-1:0]      l_raddr, l_waddr, l_wdata, l_rd_ff;
   logic [NW-1:0]      t_raddr, t_waddr;
   logic               t_wdata, t_rd_ff;

   always_ff @(posedge clock) begin
      if (e_we) edge_mem[e_waddr] <= e_wdata;
      if (e_re) e_rd_ff <= edge_mem[e_raddr];
   end

   always_ff @(posedge clock) begin
      if (l_we) link_mem[l_waddr] <= l_wdata;
      if (l_re) l_rd_ff <= link_mem[l_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) term_mem[t_waddr] <= t_wdata;
      if (t_re) t_rd_ff <= term_mem[t_raddr];
   end

   // control and context registers
   logic [4:0]    state_ff, state_in;
   logic [EW-1:0] clr_ff, clr_in;
   logic [SW-1:0] sym_ff, sym_in;
   logic          last_ff, last_in;
   logic [CW-1:0] nfree_ff, nfree_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] pats_ff, pats_in;
   logic [NW-1:0] walker_ff, walker_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [NW-1:0] fresh_ff, fresh_in;
   logic [NW-1:0] found_ff, found_in;
   logic [NW-1:0] res_ff, res_in;
   logic [NW-1:0] sp_parent_ff, sp_parent_in;
   logic [NW-1:0] sp_child_ff, sp_child_in;
   logic [NW-1:0] sp_fresh_ff, sp_fresh_in;
   logic [SW:0]   sp_b_ff, sp_b_in;
   logic [NW-1:0] sp_walker_ff, sp_walker_in;
   logic [CW-1:0] sp_steps_ff, sp_steps_in;
   logic          sp_moved_ff, sp_moved_in;
   logic          sp_loop_ff, sp_loop_in;
   logic          done_ff, done_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic          stat_ff, stat_in;
   logic          ov_valid_ff, ov_valid_in;
   logic [NW-1:0] o_node_ff, o_node_in;
   logic [CW-1:0] o_used_ff, o_used_in;
   logic          o_done_ff, o_done_in;
   logic [NW-1:0] o_idx_ff, o_idx_in;
   logic          o_stat_ff, o_stat_in;

   logic          accept;
   logic          sp_last_b;

   assign req_ready         = (state_ff == ST_IDLE);
   assign accept            = req_valid && req_ready;
   assign rsp_valid         = ov_valid_ff;
   assign rsp_active_node   = o_node_ff;
   assign rsp_nodes_used    = o_used_ff;
   assign rsp_pattern_done  = o_done_ff;
   assign rsp_pattern_index = o_idx_ff;
   assign rsp_status        = o_stat_ff;
   assign sp_last_b         = (sp_b_ff == (SW+1)'(dmpb_pkg::ALPHABET - 1));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      nfree_in     = nfree_ff;
      cur_in       = cur_ff;
      pats_in      = pats_ff;
      walker_in    = walker_ff;
      steps_in     = steps_ff;
      fresh_in     = fresh_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      sp_parent_in = sp_parent_ff;
      sp_child_in  = sp_child_ff;
      sp_fresh_in  = sp_fresh_ff;
      sp_b_in      = sp_b_ff;
      sp_walker_in = sp_walker_ff;
      sp_steps_in  = sp_steps_ff;
      sp_moved_in  = sp_moved_ff;
      sp_loop_in   = sp_loop_ff;
      done_in      = done_ff;
      idx_in       = idx_ff;
      stat_in      = stat_ff;
      ov_valid_in  = ov_valid_ff && !rsp_ready;
      o_node_in    = o_node_ff;
      o_used_in    = o_used_ff;
      o_done_in    = o_done_ff;
      o_idx_in     = o_idx_ff;
      o_stat_in    = o_stat_ff;

      e_re = 1'b0; e_we = 1'b0; e_raddr = '0; e_waddr = '0; e_wdata = '0;
      l_re = 1'b0; l_we = 1'b0; l_raddr = '0; l_waddr = '0; l_wdata = '0;
      t_re = 1'b0; t_we = 1'b0; t_raddr = '0; t_waddr = '0; t_wdata = 1'b0;

      unique case (state_ff)
         ST_CLR: begin
            e_we    = 1'b1;
            e_waddr = clr_ff;
            if (clr_ff[SW-1:0] == '0) begin
               l_we    = 1'b1;
               l_waddr = clr_ff[EW-1:SW];
               l_wdata = (clr_ff[EW-1:SW] == dmpb_pkg::ROOT_NODE) ?
                         dmpb_pkg::ROOT_NODE : dmpb_pkg::NO_NODE;
               t_we    = 1'b1;
               t_waddr = clr_ff[EW-1:SW];
            end
            clr_in = clr_ff + EW'(1);
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               sym_in  = req_symbol;
               last_in = req_last_of_pattern;
               done_in = 1'b0;
               idx_in  = '0;
               if ((CW'(dmpb_pkg::NODE_CAP) - nfree_ff) < CW'(2)) begin
                  stat_in  = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  stat_in = 1'b0;
                  if (req_first_of_pattern) cur_in = dmpb_pkg::ROOT_NODE;
                  state_in = ST_U_RD;
               end
            end
         end
         ST_U_RD: begin
            e_re     = 1'b1;
            e_raddr  = {cur_ff, sym_ff};
            state_in = ST_U_WT;
         end
         ST_U_WT: begin
            if (e_rd_ff.target != '0) begin
               if (e_rd_ff.primary) begin
                  res_in   = e_rd_ff.target;
                  state_in = ST_FIN;
               end else begin
                  sp_parent_in = cur_ff;
                  sp_child_in  = e_rd_ff.target;
                  sp_fresh_in  = nfree_ff[NW-1:0];
                  nfree_in     = nfree_ff + CW'(1);
                  sp_loop_in   = 1'b0;
                  state_in     = ST_S_TRD;
               end
            end else begin
               fresh_in        = nfree_ff[NW-1:0];
               nfree_in        = nfree_ff + CW'(1);
               e_we            = 1'b1;
               e_waddr         = {cur_ff, sym_ff};
               e_wdata.target  = nfree_ff[NW-1:0];
               e_wdata.primary = 1'b1;
               walker_in       = cur_ff;
               found_in        = dmpb_pkg::NO_NODE;
               steps_in        = '0;
               state_in        = ST_W_CHK;
            end
         end
         ST_W_CHK: begin
            if (walker_ff == dmpb_pkg::ROOT_NODE || found_ff != '0 ||
                steps_ff >= CW'(dmpb_pkg::NODE_CAP)) begin
               l_we     = 1'b1;
               l_waddr  = fresh_ff;
               l_wdata  = (found_ff != '0) ? found_ff : dmpb_pkg::ROOT_NODE;
               res_in   = fresh_ff;
               state_in = ST_FIN;
            end else begin
               l_re     = 1'b1;
               l_raddr  = walker_ff;
               state_in = ST_W_LNK;
            end
         end
         ST_W_LNK: begin
            walker_in = l_rd_ff;
            steps_in  = steps_ff + CW'(1);
            e_re      = 1'b1;
            e_raddr   = {l_rd_ff, sym_ff};
            state_in  = ST_W_EDG;
         end
         ST_W_EDG: begin
            if (e_rd_ff.target != '0) begin
               if (e_rd_ff.primary) begin
                  found_in = e_rd_ff.target;
                  state_in = ST_W_CHK;
               end else begin
                  sp_parent_in = walker_ff;
                  sp_child_in  = e_rd_ff.target;
                  sp_fresh_in  = nfree_ff[NW-1:0];
                  nfree_in     = nfree_ff + CW'(1);
                  sp_loop_in   = 1'b1;
                  state_in     = ST_S_TRD;
               end
            end else begin
               e_we            = 1'b1;
               e_waddr         = {walker_ff, sym_ff};
               e_wdata.target  = fresh_ff;
               e_wdata.primary = 1'b0;
               state_in        = ST_W_CHK;
            end
         end
         ST_S_TRD: begin
            t_re     = 1'b1;
            t_raddr  = sp_child_ff;
            state_in = ST_S_TWT;
         end
         ST_S_TWT: begin
            t_we            = 1'b1;
            t_waddr         = sp_fresh_ff;
            t_wdata         = t_rd_ff;
            e_we            = 1'b1;
            e_waddr         = {sp_parent_ff, sym_ff};
            e_wdata.target  = sp_fresh_ff;
            e_wdata.primary = 1'b1;
            sp_b_in         = '0;
            state_in        = ST_S_CRD;
         end
         ST_S_CRD: begin
            e_re     = 1'b1;
            e_raddr  = {sp_child_ff, sp_b_ff[SW-1:0]};
            state_in = ST_S_CWT;
         end
         ST_S_CWT: begin
            if (e_rd_ff.target != '0) begin
               e_we            = 1'b1;
               e_waddr         = {sp_fresh_ff, sp_b_ff[SW-1:0]};
               e_wdata.target  = e_rd_ff.target;
               e_wdata.primary = 1'b0;
            end
            sp_b_in  = sp_b_ff + (SW+1)'(1);
            state_in = sp_last_b ? ST_S_L1 : ST_S_CRD;
         end
         ST_S_L1: begin
            l_re     = 1'b1;
            l_raddr  = sp_child_ff;
            state_in = ST_S_L2;
         end
         ST_S_L2: begin
            l_we     = 1'b1;
            l_waddr  = sp_fresh_ff;
            l_wdata  = l_rd_ff;
            state_in = ST_S_L3;
         end
         ST_S_L3: begin
            l_we         = 1'b1;
            l_waddr      = sp_child_ff;
            l_wdata      = sp_fresh_ff;
            sp_walker_in = sp_parent_ff;
            sp_steps_in  = '0;
            state_in     = ST_S_WCHK;
         end
         ST_S_WCHK: begin
            if (sp_walker_ff == dmpb_pkg::ROOT_NODE ||
                sp_steps_ff >= CW'(dmpb_pkg::NODE_CAP)) begin
               if (sp_loop_ff) begin
                  found_in = sp_fresh_ff;
                  state_in = ST_W_CHK;
               end else begin
                  res_in   = sp_fresh_ff;
                  state_in = ST_FIN;
               end
            end else begin
               l_re     = 1'b1;
               l_raddr  = sp_walker_ff;
               state_in = ST_S_WLNK;
            end
         end
         ST_S_WLNK: begin
            sp_walker_in = l_rd_ff;
            sp_steps_in  = sp_steps_ff + CW'(1);
            sp_b_in      = '0;
            sp_moved_in  = 1'b0;
            state_in     = ST_S_ERD;
         end
         ST_S_ERD: begin
            e_re     = 1'b1;
            e_raddr  = {sp_walker_ff, sp_b_ff[SW-1:0]};
            state_in = ST_S_EWT;
         end
         ST_S_EWT: begin
            if (e_rd_ff.target == sp_child_ff && e_rd_ff.primary) begin
               // primary edge into the split node ends this chain node
               sp_steps_in = sp_moved_ff ? sp_steps_ff : CW'(dmpb_pkg::NODE_CAP);
               state_in    = ST_S_WCHK;
            end else begin
               if (e_rd_ff.target == sp_child_ff) begin
                  e_we            = 1'b1;
                  e_waddr         = {sp_walker_ff, sp_b_ff[SW-1:0]};
                  e_wdata.target  = sp_fresh_ff;
                  e_wdata.primary = 1'b0;
                  sp_moved_in     = 1'b1;
               end
               sp_b_in = sp_b_ff + (SW+1)'(1);
               if (sp_last_b) begin
                  if (!sp_moved_in) sp_steps_in = CW'(dmpb_pkg::NODE_CAP);
                  state_in = ST_S_WCHK;
               end else begin
                  state_in = ST_S_ERD;
               end
            end
         end
         ST_FIN: begin
            cur_in = res_ff;
            if (last_ff) begin
               walker_in = res_ff;
               steps_in  = '0;
               state_in  = ST_T_SET;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_T_SET: begin
            t_we     = 1'b1;
            t_waddr  = walker_ff;
            t_wdata  = 1'b1;
            l_re     = 1'b1;
            l_raddr  = walker_ff;
            steps_in = steps_ff + CW'(1);
            state_in = ST_T_WT;
         end
         ST_T_WT: begin
            walker_in = l_rd_ff;
            if (l_rd_ff != dmpb_pkg::ROOT_NODE && steps_ff < CW'(dmpb_pkg::NODE_CAP)) begin
               state_in = ST_T_SET;
            end else begin
               done_in = 1'b1;
               idx_in  = pats_ff;
               if (pats_ff < NW'(dmpb_pkg::PAT_MAX)) pats_in = pats_ff + NW'(1);
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!ov_valid_ff || rsp_ready) begin
               ov_valid_in = 1'b1;
               o_node_in   = cur_ff;
               o_used_in   = nfree_ff;
               o_done_in   = done_ff;
               o_idx_in    = idx_ff;
               o_stat_in   = stat_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLR;
         clr_ff      <= '0;
         nfree_ff    <= CW'(2);
         cur_ff      <= dmpb_pkg::ROOT_NODE;
         pats_ff     <= '0;
         ov_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         nfree_ff    <= nfree_in;
         cur_ff      <= cur_in;
         pats_ff     <= pats_in;
         ov_valid_ff <= ov_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      last_ff      <= last_in;
      walker_ff    <= walker_in;
      steps_ff     <= steps_in;
      fresh_ff     <= fresh_in;
      found_ff     <= found_in;
      res_ff       <= res_in;
      sp_parent_ff <= sp_parent_in;
      sp_child_ff  <= sp_child_in;
      sp_fresh_ff  <= sp_fresh_in;
      sp_b_ff      <= sp_b_in;
      sp_walker_ff <= sp_walker_in;
      sp_steps_ff  <= sp_steps_in;
      sp_moved_ff  <= sp_moved_in;
      sp_loop_ff   <= sp_loop_in;
      done_ff      <= done_in;
      idx_ff       <= idx_in;
      stat_ff      <= stat_in;
      o_node_ff    <= o_node_in;
      o_used_ff    <= o_used_in;
      o_done_ff    <= o_done_in;
      o_idx_ff     <= o_idx_in;
      o_stat_ff    <= o_stat_in;
   end

   a_nfree_bound: assert property (@(posedge clock) disable iff (reset)
      nfree_ff <= CW'(dmpb_pkg::NODE_CAP))
      else $error("node counter beyond capacity");

   a_cur_defined: assert property (@(posedge clock) disable iff (reset)
      cur_ff != dmpb_pkg::NO_NODE)
      else $error("current node undefined");

   a_edge_node: assert property (@(posedge clock) disable iff (reset)
      (e_we && state_ff != ST_CLR) |-> e_waddr[EW-1:SW] != dmpb_pkg::NO_NODE)
      else $error("edge write to undefined node");

   a_overflow_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && (CW'(dmpb_pkg::NODE_CAP) - nfree_ff) < CW'(2)) |=> state_ff == ST_RESP)
      else $error("overflow request not dropped");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> nfree_ff == $past(nfree_ff))
      else $error("node allocated outside a request");

endmodule
